// ===== hdl/rsakg_pkg.sv =====
// Shared types and constants for the RSA key pair generator.
package rsakg_pkg;
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_PRIME = 2'd1;
  localparam logic [1:0] STATUS_NOT_COPR  = 2'd2;
  localparam logic [31:0] DEFAULT_EXP     = 32'd65537;
  localparam int unsigned DIV_W           = 64;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } rsakg_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } rsakg_div_rsp_t;
endpackage

// ===== hdl/rsakg_if.sv =====
// Valid/ready channel interfaces for requests, results and configuration.
interface rsakg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] prime_p;
  logic [15:0] prime_q;
  modport source (output valid, prime_p, prime_q, input ready);
  modport sink   (input valid, prime_p, prime_q, output ready);
endinterface

interface rsakg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] modulus;
  logic [31:0] private_exponent;
  modport source (output valid, status, modulus, private_exponent, input ready);
  modport sink   (input valid, status, modulus, private_exponent, output ready);
endinterface

interface rsakg_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/rsakg_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
module rsakg_div import rsakg_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  rsakg_div_req_t req,
  output rsakg_div_rsp_t rsp
);
  logic [63:0] quot_r, quot_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dsr_r, dsr_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;

  always_comb begin
    shifted  = {rem_r, quot_r[63]};
    diff     = shifted - {1'b0, dsr_r};
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = 7'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[64]) begin
        rem_nxt  = diff[63:0];
        quot_nxt = {quot_r[62:0], 1'b1};
      end else begin
        rem_nxt  = shifted[63:0];
        quot_nxt = {quot_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;
endmodule

// ===== hdl/rsakg_mul.sv =====
// Shared 32x32 multiplier with registered product.
module rsakg_mul (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod
);
  logic [63:0] prod_r;
  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end
  assign prod = prod_r;
endmodule

// ===== hdl/rsa_key_pair_generator_top.sv =====
// Top level: sequencer for trial division, gcd and extended Euclid.
// Run time is data dependent; every division uses the shared divider.
// A 16-bit prime needs up to 86 divisions; gcd and inverse take up to ~47
// division steps each. A small p that is rejected in S_PCHK needs no division.
// Throughput: one request at a time; in_ready high only when idle with no
// result waiting. Reset (synchronous, rst_n low): sequencer idle, no result, e = 65537.
module rsa_key_pair_generator_top import rsakg_pkg::*; #(
  parameter int PRIME_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  rsakg_in_if.sink    in_ch,
  rsakg_out_if.source out_ch,
  rsakg_cfg_if.sink   cfg_ch
);
  // state codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PCHK   = 4'd1;  // small cases of current candidate
  localparam logic [3:0] S_PDIV   = 4'd2;  // divide candidate by trial value
  localparam logic [3:0] S_PWAIT  = 4'd3;
  localparam logic [3:0] S_MUL_N  = 4'd4;
  localparam logic [3:0] S_MUL_P  = 4'd5;
  localparam logic [3:0] S_MUL_W  = 4'd6;
  localparam logic [3:0] S_GDIV   = 4'd7;
  localparam logic [3:0] S_GWAIT  = 4'd8;
  localparam logic [3:0] S_IDIV   = 4'd9;
  localparam logic [3:0] S_IWAIT  = 4'd10;
  localparam logic [3:0] S_IMUL   = 4'd11;
  localparam logic [3:0] S_IUPD   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;
  localparam logic [3:0] S_KSQ    = 4'd14;  // k*k product wait

  localparam logic [31:0] PMASK = (PRIME_BITS >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << PRIME_BITS) - 64'd1);

  logic [3:0]  state_r, state_nxt;
  logic [31:0] exp_r;
  logic [15:0] p_r, q_r;
  logic        which_r, which_nxt;        // 0: testing p, 1: testing q
  logic [17:0] k_r, k_nxt;                // trial divisor base 6k-1
  logic [1:0]  tsel_r, tsel_nxt;          // 0:2 1:3 2:k 3:k+2
  logic [63:0] n_r, n_nxt, phi_r, phi_nxt;
  logic [63:0] x_r, x_nxt, y_r, y_nxt;    // gcd / remainder pair
  logic [63:0] a_r, a_nxt, na_r, na_nxt;
  logic        odd_r, odd_nxt;            // index parity of a
  logic        any_r, any_nxt;            // index nonzero
  logic [63:0] qt_r, qt_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [31:0] d_r, d_nxt, mod_r, mod_nxt;
  logic        ov_r, ov_nxt;

  rsakg_div_req_t dreq;
  rsakg_div_rsp_t drsp;
  logic [31:0] ma, mb;
  logic [63:0] mprod;

  rsakg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  rsakg_mul u_mul (.clk(clk), .op_a(ma), .op_b(mb), .prod(mprod));

  logic [15:0] cand;
  logic [63:0] tdiv;
  logic        in_take;                   // request accepted this cycle
  assign cand = which_r ? q_r : p_r;

  always_comb begin
    unique case (tsel_r)
      2'd0:    tdiv = 64'd2;
      2'd1:    tdiv = 64'd3;
      2'd2:    tdiv = 64'(k_r);
      default: tdiv = 64'(k_r) + 64'd2;
    endcase
  end

  // result registers stay put until taken, so hold off new requests meanwhile
  assign in_ch.ready  = (state_r == S_IDLE) && !ov_r;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.status = st_r;
  assign out_ch.modulus = mod_r;
  assign out_ch.private_exponent = d_r;

  always_comb begin
    state_nxt = state_r; which_nxt = which_r; k_nxt = k_r; tsel_nxt = tsel_r;
    n_nxt = n_r; phi_nxt = phi_r; x_nxt = x_r; y_nxt = y_r;
    a_nxt = a_r; na_nxt = na_r; odd_nxt = odd_r; any_nxt = any_r;
    qt_nxt = qt_r; st_nxt = st_r; d_nxt = d_r; mod_nxt = mod_r; ov_nxt = ov_r;
    dreq = '{start: 1'b0, dividend: '0, divisor: 64'd1};
    ma = 32'(k_r); mb = 32'(k_r);
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          which_nxt = 1'b0;
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        // 0/1 not prime, 2/3 prime, else test 2 and 3 then 6k+-1
        if (cand <= 16'd1) begin
          st_nxt = STATUS_NOT_PRIME; state_nxt = S_OUT;
        end else if (cand <= 16'd3) begin
          if (which_r) state_nxt = S_MUL_N;
          else which_nxt = 1'b1;
        end else begin
          tsel_nxt = 2'd0; k_nxt = 18'd5; state_nxt = S_PDIV;
        end
      end
      S_PDIV: begin
        dreq.start = 1'b1; dreq.dividend = 64'(cand); dreq.divisor = tdiv;
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        if (drsp.done) begin
          if (drsp.rem == 64'd0) begin
            st_nxt = STATUS_NOT_PRIME; state_nxt = S_OUT;
          end else begin
            unique case (tsel_r)
              2'd0: begin tsel_nxt = 2'd1; state_nxt = S_PDIV; end
              2'd1: begin tsel_nxt = 2'd2; state_nxt = S_KSQ; end
              2'd2: begin tsel_nxt = 2'd3; state_nxt = S_PDIV; end
              default: begin
                tsel_nxt = 2'd2; k_nxt = k_r + 18'd6; state_nxt = S_KSQ;
              end
            endcase
          end
        end
      end
      S_KSQ: state_nxt = S_MUL_W;
      S_MUL_W: begin
        // k*k <= cand ? keep dividing : candidate is prime
        if (mprod <= 64'(cand)) state_nxt = S_PDIV;
        else if (which_r) state_nxt = S_MUL_N;
        else begin which_nxt = 1'b1; state_nxt = S_PCHK; end
      end
      S_MUL_N: begin
        ma = 32'(p_r); mb = 32'(q_r);
        state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        n_nxt = mprod;
        ma = 32'(p_r) - 32'd1; mb = 32'(q_r) - 32'd1;
        state_nxt = S_GDIV;
        x_nxt = 64'(exp_r); y_nxt = '0; any_nxt = 1'b0; // y loaded next
        tsel_nxt = 2'd0;
      end
      S_GDIV: begin
        if (tsel_r == 2'd0) begin
          // first cycle: capture phi
          phi_nxt = mprod; y_nxt = mprod; tsel_nxt = 2'd1;
        end else if (y_r == 64'd0) begin
          if (x_r != 64'd1) begin
            st_nxt = STATUS_NOT_COPR; state_nxt = S_OUT;
          end else begin
            x_nxt = phi_r; y_nxt = 64'(exp_r);
            a_nxt = '0; na_nxt = 64'd1; odd_nxt = 1'b0; any_nxt = 1'b0;
            state_nxt = S_IDIV;
          end
        end else begin
          dreq.start = 1'b1; dreq.dividend = x_r; dreq.divisor = y_r;
          state_nxt = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (drsp.done) begin
          x_nxt = y_r; y_nxt = drsp.rem; state_nxt = S_GDIV;
        end
      end
      S_IDIV: begin
        if (y_r == 64'd0) begin
          st_nxt = STATUS_OK; mod_nxt = n_r[31:0];
          if (!any_r || a_r == 64'd0) d_nxt = '0;
          else if (odd_r) d_nxt = a_r[31:0];
          else d_nxt = phi_r[31:0] - a_r[31:0];
          state_nxt = S_OUT;
        end else begin
          dreq.start = 1'b1; dreq.dividend = x_r; dreq.divisor = y_r;
          state_nxt = S_IWAIT;
        end
      end
      S_IWAIT: begin
        if (drsp.done) begin
          qt_nxt = drsp.quot; x_nxt = y_r; y_nxt = drsp.rem;
          state_nxt = S_IMUL;
        end
      end
      S_IMUL: begin
        // coefficients stay below phi < 2^32
        ma = qt_r[31:0]; mb = na_r[31:0];
        state_nxt = S_IUPD;
      end
      S_IUPD: begin
        a_nxt = na_r; na_nxt = a_r + mprod;
        odd_nxt = ~odd_r; any_nxt = 1'b1;
        state_nxt = S_IDIV;
      end
      S_OUT: begin
        if (st_r != STATUS_OK) begin mod_nxt = '0; d_nxt = '0; end
        if (!ov_r) begin ov_nxt = 1'b1; state_nxt = S_IDLE; end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      exp_r   <= DEFAULT_EXP;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_ch.valid) exp_r <= cfg_ch.data;
    end
    if (in_take) begin
      p_r <= in_ch.prime_p & PMASK[15:0];
      q_r <= in_ch.prime_q & PMASK[15:0];
    end
    which_r <= which_nxt; k_r <= k_nxt; tsel_r <= tsel_nxt;
    n_r <= n_nxt; phi_r <= phi_nxt; x_r <= x_nxt; y_r <= y_nxt;
    a_r <= a_nxt; na_r <= na_nxt; odd_r <= odd_nxt; any_r <= any_nxt;
    qt_r <= qt_nxt; st_r <= st_nxt; d_r <= d_nxt; mod_r <= mod_nxt;
  end
endmodule
